/* src/esc_pkg.sv */
// Package: shared constants, sequencer codes and arithmetic helpers for the compensation block.
package esc_pkg;

	// Sequencer state codes
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_T0   = 5'd1;
	localparam logic [4:0] ST_T1   = 5'd2;
	localparam logic [4:0] ST_T2   = 5'd3;
	localparam logic [4:0] ST_T3   = 5'd4;
	localparam logic [4:0] ST_T4   = 5'd5;
	localparam logic [4:0] ST_P0   = 5'd6;
	localparam logic [4:0] ST_P1   = 5'd7;
	localparam logic [4:0] ST_P2   = 5'd8;
	localparam logic [4:0] ST_P3   = 5'd9;
	localparam logic [4:0] ST_P4   = 5'd10;
	localparam logic [4:0] ST_P5   = 5'd11;
	localparam logic [4:0] ST_P6   = 5'd12;
	localparam logic [4:0] ST_DIV  = 5'd13;
	localparam logic [4:0] ST_P7   = 5'd14;
	localparam logic [4:0] ST_P8   = 5'd15;
	localparam logic [4:0] ST_P9   = 5'd16;
	localparam logic [4:0] ST_P10  = 5'd17;
	localparam logic [4:0] ST_H0   = 5'd18;
	localparam logic [4:0] ST_H1   = 5'd19;
	localparam logic [4:0] ST_H2   = 5'd20;
	localparam logic [4:0] ST_H3   = 5'd21;
	localparam logic [4:0] ST_H4   = 5'd22;
	localparam logic [4:0] ST_H5   = 5'd23;
	localparam logic [4:0] ST_H6   = 5'd24;
	localparam logic [4:0] ST_H7   = 5'd25;
	localparam logic [4:0] ST_H8   = 5'd26;
	localparam logic [4:0] ST_MUL  = 5'd27;

	// Configuration register indexes
	localparam logic [2:0] REG_CALIB_TEMP  = 3'd0;
	localparam logic [2:0] REG_CALIB_PA    = 3'd1;
	localparam logic [2:0] REG_CALIB_PB    = 3'd2;
	localparam logic [2:0] REG_CALIB_P9    = 3'd3;
	localparam logic [2:0] REG_CALIB_HUMID = 3'd4;

	// Compensation constants
	localparam logic [63:0] K_T_OFFSET  = 64'd128000;
	localparam logic [63:0] K_SCALE     = 64'd3125;
	localparam logic [63:0] K_P_FULL    = 64'd1048576;
	localparam logic [63:0] K_H_OFFSET  = 64'd76800;
	localparam logic [63:0] K_H_MAX     = 64'd419430400;
	localparam logic [63:0] K_H_BIAS_E  = 64'd2097152;
	localparam logic [63:0] K_H_RND_A   = 64'd16384;
	localparam logic [63:0] K_H_BIAS_C  = 64'd32768;
	localparam logic [63:0] K_H_RND_E   = 64'd8192;
	localparam logic [63:0] K_P_BIAS    = 64'h0000_8000_0000_0000;
	localparam logic [63:0] K_T_RND     = 64'd128;

	typedef logic [63:0] word_t;

	// Wrap to 32-bit two's complement, sign-extended to 64 bits
	function automatic word_t w32(input word_t x);
		return {{32{x[31]}}, x[31:0]};
	endfunction

	// Arithmetic right shift of a 64-bit pattern
	function automatic word_t sra(input word_t x, input logic [5:0] n);
		return word_t'($signed(x) >>> n);
	endfunction

	// Sign-extend a 16-bit field
	function automatic word_t sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// Sign-extend a 12-bit field
	function automatic word_t sx12(input logic [11:0] v);
		return {{52{v[11]}}, v};
	endfunction

endpackage

/* src/env_sensor_compensation.sv */
// Top level: sequenced integer compensation of temperature, pressure and humidity readings.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------------
//  in       | in_valid / in_stall    | raw_pressure, raw_temperature, raw_humidity
//  out      | out_valid / out_stall  | temp_centideg, pressure_q24_8, humidity_q22_10,
//           |                        | pressure_held
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One transaction, from acceptance to the next acceptance, runs 21 products through the
// one 32x32 multiplier in partial-product phases, the sequencing steps, the radix-2
// divider and one idle state. A held pressure skips the divider and four products.
// in_stall stays high from acceptance until the result is loaded into the output register.
// The output register holds a result under out_stall while the next transaction is worked.
// Reset clears calibration, the last pressure and all control state; cfg_ready is always high.
module env_sensor_compensation (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [19:0]         raw_pressure,
	input  logic [19:0]         raw_temperature,
	input  logic [15:0]         raw_humidity,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  temp_centideg,
	output logic signed [31:0]  pressure_q24_8,
	output logic [16:0]         humidity_q22_10,
	output logic                pressure_held,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  esc_pkg::word_t      cfg_data
);
	import esc_pkg::*;

	logic [4:0]  state_q, ret_q;
	logic [1:0]  mul_ph_q;
	logic [5:0]  div_cnt_q;
	logic [47:0] cal_t_q;
	word_t       cal_pa_q, cal_pb_q, cal_h_q;
	logic [15:0] cal_p9_q;
	logic [31:0] last_q;
	logic [19:0] adc_p_q, adc_t_q;
	logic [15:0] adc_h_q;
	word_t       ma_q, mb_q, mr_q, prod_s1, acc_q;
	word_t       tf_q, temp_q, pa_q, pb_q, pc_q, hx_q, ha_q, hb_q;
	word_t       dq_q, rm_q, dv_q;
	logic        dneg_q, dsign_q;
	logic        out_valid_q, held_q;
	logic [31:0] out_t_q, out_p_q;
	logic [16:0] out_h_q;

	word_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
	logic [31:0] mul_a, mul_b;
	logic [64:0] div_sh, div_diff;
	word_t p5_div, hum_x, hum_c, quot;
	logic  out_free;
	logic  out_load;

	// Unpack calibration words
	always_comb begin
		t1 = {48'd0, cal_t_q[15:0]};
		t2 = sx16(cal_t_q[31:16]);
		t3 = sx16(cal_t_q[47:32]);
		p1 = {48'd0, cal_pa_q[15:0]};
		p2 = sx16(cal_pa_q[31:16]);
		p3 = sx16(cal_pa_q[47:32]);
		p4 = sx16(cal_pa_q[63:48]);
		p5 = sx16(cal_pb_q[15:0]);
		p6 = sx16(cal_pb_q[31:16]);
		p7 = sx16(cal_pb_q[47:32]);
		p8 = sx16(cal_pb_q[63:48]);
		p9 = sx16(cal_p9_q);
		h1 = {56'd0, cal_h_q[7:0]};
		h2 = sx16(cal_h_q[23:8]);
		h3 = {56'd0, cal_h_q[31:24]};
		h4 = sx12({cal_h_q[39:32], cal_h_q[43:40]});
		h5 = sx12({cal_h_q[55:48], cal_h_q[47:44]});
		h6 = {{56{cal_h_q[63]}}, cal_h_q[63:56]};
	end

	// Select the partial-product operands for the shared multiplier
	always_comb begin
		mul_a = (mul_ph_q == 2'd2) ? ma_q[63:32] : ma_q[31:0];
		mul_b = (mul_ph_q == 2'd1) ? mb_q[63:32] : mb_q[31:0];
	end

	// Radix-2 restoring divide step and helper values
	always_comb begin
		div_sh   = {rm_q, dq_q[63]};
		div_diff = div_sh - {1'b0, dv_q};
		p5_div   = sra(mr_q, 6'd33);
		quot     = dneg_q ? (64'd0 - dq_q) : dq_q;
		hum_x    = w32(hx_q - sra(w32(mr_q), 6'd4));
		if (hum_x[63])
			hum_c = 64'd0;
		else if (hum_x > K_H_MAX)
			hum_c = K_H_MAX;
		else
			hum_c = hum_x;
		out_free = !out_valid_q || !out_stall;
		out_load = (state_q == ST_H8) && out_free;
	end

	assign in_stall        = (state_q != ST_IDLE);
	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign temp_centideg   = out_t_q;
	assign pressure_q24_8  = out_p_q;
	assign humidity_q22_10 = out_h_q;
	assign pressure_held   = held_q;

	// Hold calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t_q  <= '0;
			cal_pa_q <= '0;
			cal_pb_q <= '0;
			cal_p9_q <= '0;
			cal_h_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CALIB_TEMP:  cal_t_q  <= cfg_data[47:0];
				REG_CALIB_PA:    cal_pa_q <= cfg_data;
				REG_CALIB_PB:    cal_pb_q <= cfg_data;
				REG_CALIB_P9:    cal_p9_q <= cfg_data[15:0];
				REG_CALIB_HUMID: cal_h_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Raise valid on a new result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequence the compensation through the shared multiplier and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			mul_ph_q    <= '0;
			div_cnt_q   <= '0;
			last_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						adc_p_q <= raw_pressure;
						adc_t_q <= raw_temperature;
						adc_h_q <= raw_humidity;
						state_q <= ST_T0;
					end
				end
				ST_MUL: begin
					mul_ph_q <= mul_ph_q + 2'd1;
					prod_s1  <= {32'd0, mul_a} * {32'd0, mul_b};
					case (mul_ph_q)
						2'd0: ;
						2'd1: acc_q <= prod_s1;
						2'd2: acc_q <= acc_q + {prod_s1[31:0], 32'd0};
						default: begin
							mr_q    <= acc_q + {prod_s1[31:0], 32'd0};
							state_q <= ret_q;
						end
					endcase
				end
				ST_T0: begin
					ma_q <= {47'd0, adc_t_q[19:3]} - (t1 << 1);
					mb_q <= t2;
					ret_q <= ST_T1; state_q <= ST_MUL;
				end
				ST_T1: begin
					pa_q <= sra(w32(mr_q), 6'd11);
					ma_q <= {48'd0, adc_t_q[19:4]} - t1;
					mb_q <= {48'd0, adc_t_q[19:4]} - t1;
					ret_q <= ST_T2; state_q <= ST_MUL;
				end
				ST_T2: begin
					ma_q <= sra(w32(mr_q), 6'd12);
					mb_q <= t3;
					ret_q <= ST_T3; state_q <= ST_MUL;
				end
				ST_T3: begin
					tf_q    <= w32(pa_q + sra(w32(mr_q), 6'd14));
					state_q <= ST_T4;
				end
				ST_T4: begin
					temp_q <= sra(w32((tf_q << 2) + tf_q + K_T_RND), 6'd8);
					pa_q   <= tf_q - K_T_OFFSET;
					ma_q   <= tf_q - K_T_OFFSET;
					mb_q   <= tf_q - K_T_OFFSET;
					ret_q  <= ST_P0; state_q <= ST_MUL;
				end
				ST_P0: begin
					pc_q <= mr_q;
					ma_q <= mr_q;
					mb_q <= p6;
					ret_q <= ST_P1; state_q <= ST_MUL;
				end
				ST_P1: begin
					pb_q <= mr_q;
					ma_q <= pa_q;
					mb_q <= p5;
					ret_q <= ST_P2; state_q <= ST_MUL;
				end
				ST_P2: begin
					pb_q <= pb_q + (mr_q << 17) + (p4 << 35);
					ma_q <= pc_q;
					mb_q <= p3;
					ret_q <= ST_P3; state_q <= ST_MUL;
				end
				ST_P3: begin
					pc_q <= sra(mr_q, 6'd8);
					ma_q <= pa_q;
					mb_q <= p2;
					ret_q <= ST_P4; state_q <= ST_MUL;
				end
				ST_P4: begin
					ma_q <= pc_q + (mr_q << 12) + K_P_BIAS;
					mb_q <= p1;
					ret_q <= ST_P5; state_q <= ST_MUL;
				end
				ST_P5: begin
					if (p5_div == 64'd0) begin
						// keep the last pressure and flag it
						pc_q    <= {32'd0, last_q};
						dsign_q <= 1'b1;
						state_q <= ST_H0;
					end else begin
						dsign_q <= 1'b0;
						dneg_q  <= p5_div[63];
						dv_q    <= p5_div[63] ? (64'd0 - p5_div) : p5_div;
						ma_q    <= ((K_P_FULL - {44'd0, adc_p_q}) << 31) - pb_q;
						mb_q    <= K_SCALE;
						ret_q   <= ST_P6; state_q <= ST_MUL;
					end
				end
				ST_P6: begin
					dq_q      <= mr_q[63] ? (64'd0 - mr_q) : mr_q;
					dneg_q    <= dneg_q ^ mr_q[63];
					rm_q      <= '0;
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					// advance one quotient bit
					if (!div_diff[64]) begin
						rm_q <= div_diff[63:0];
						dq_q <= {dq_q[62:0], 1'b1};
					end else begin
						rm_q <= div_sh[63:0];
						dq_q <= {dq_q[62:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'd63)
						state_q <= ST_P7;
				end
				ST_P7: begin
					pc_q <= quot;
					ma_q <= sra(quot, 6'd13);
					mb_q <= sra(quot, 6'd13);
					ret_q <= ST_P8; state_q <= ST_MUL;
				end
				ST_P8: begin
					ma_q <= mr_q;
					mb_q <= p9;
					ret_q <= ST_P9; state_q <= ST_MUL;
				end
				ST_P9: begin
					pa_q <= sra(mr_q, 6'd25);
					ma_q <= p8;
					mb_q <= pc_q;
					ret_q <= ST_P10; state_q <= ST_MUL;
				end
				ST_P10: begin
					pc_q[31:0] <= 32'(sra(pc_q + pa_q + sra(mr_q, 6'd19), 6'd8) + (p7 << 4));
					last_q     <= 32'(sra(pc_q + pa_q + sra(mr_q, 6'd19), 6'd8) + (p7 << 4));
					state_q    <= ST_H0;
				end
				ST_H0: begin
					hx_q <= w32(tf_q - K_H_OFFSET);
					ma_q <= h5;
					mb_q <= w32(tf_q - K_H_OFFSET);
					ret_q <= ST_H1; state_q <= ST_MUL;
				end
				ST_H1: begin
					ha_q <= sra(w32(({48'd0, adc_h_q} << 14) - (h4 << 20) - mr_q + K_H_RND_A),
						6'd15);
					ma_q <= hx_q;
					mb_q <= h6;
					ret_q <= ST_H2; state_q <= ST_MUL;
				end
				ST_H2: begin
					hb_q <= sra(w32(mr_q), 6'd10);
					ma_q <= hx_q;
					mb_q <= h3;
					ret_q <= ST_H3; state_q <= ST_MUL;
				end
				ST_H3: begin
					ma_q <= hb_q;
					mb_q <= sra(w32(mr_q), 6'd11) + K_H_BIAS_C;
					ret_q <= ST_H4; state_q <= ST_MUL;
				end
				ST_H4: begin
					ma_q <= sra(w32(mr_q), 6'd10) + K_H_BIAS_E;
					mb_q <= h2;
					ret_q <= ST_H5; state_q <= ST_MUL;
				end
				ST_H5: begin
					ma_q <= ha_q;
					mb_q <= sra(w32(mr_q + K_H_RND_E), 6'd14);
					ret_q <= ST_H6; state_q <= ST_MUL;
				end
				ST_H6: begin
					hx_q <= w32(mr_q);
					ma_q <= sra(w32(mr_q), 6'd15);
					mb_q <= sra(w32(mr_q), 6'd15);
					ret_q <= ST_H7; state_q <= ST_MUL;
				end
				ST_H7: begin
					ma_q <= sra(w32(mr_q), 6'd7);
					mb_q <= h1;
					ret_q <= ST_H8; state_q <= ST_MUL;
				end
				ST_H8: begin
					// load the output register once it is free
					if (out_load) begin
						out_t_q     <= temp_q[31:0];
						out_p_q     <= pc_q[31:0];
						out_h_q     <= hum_c[28:12];
						held_q      <= dsign_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Multiplier phases run only inside a product
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_ph_q != 2'd0 |-> state_q == ST_MUL)
		else $error("multiplier phase outside product");

	// Divider count runs only inside the divide
	assert property (@(posedge clk) disable iff (!arst_n)
		div_cnt_q != 6'd0 |-> state_q == ST_DIV)
		else $error("divider count outside divide");

	// A held pressure repeats the last computed pressure
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && held_q |-> out_p_q == last_q)
		else $error("held pressure differs from last pressure");

	// Humidity stays within the clamp
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_h_q <= 17'd102400)
		else $error("humidity beyond clamp");

endmodule

/* tb/env_sensor_compensation_tb.sv */
// Testbench for the sensor compensation block: a scoreboard class predicts each result.

class compensation_scoreboard;
	logic [47:0] calib_temp;
	logic [63:0] calib_press_a;
	logic [63:0] calib_press_b;
	logic [15:0] calib_press_nine;
	logic [63:0] calib_humid;
	logic [31:0] last_pressure;
	logic [31:0] exp_temp[$];
	logic [31:0] exp_press[$];
	logic [16:0] exp_humid[$];
	logic exp_held[$];
	int errors;
	int checked;
	int held_seen;
	int clamp_seen;

	function new();
		calib_temp = '0;
		calib_press_a = '0;
		calib_press_b = '0;
		calib_press_nine = '0;
		calib_humid = '0;
		last_pressure = '0;
		errors = 0;
		checked = 0;
		held_seen = 0;
		clamp_seen = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [63:0] value);
		case (idx)
			esc_pkg::REG_CALIB_TEMP:  calib_temp = value[47:0];
			esc_pkg::REG_CALIB_PA:    calib_press_a = value;
			esc_pkg::REG_CALIB_PB:    calib_press_b = value;
			esc_pkg::REG_CALIB_P9:    calib_press_nine = value[15:0];
			esc_pkg::REG_CALIB_HUMID: calib_humid = value;
			default: ;
		endcase
	endfunction

	function int pending();
		return exp_temp.size();
	endfunction

	// Wrap to signed 32 bits
	function longint s32(longint x);
		return longint'(int'(x));
	endfunction

	// Compute the compensated readings of one transaction and queue them
	function void note_input(logic [19:0] adc_p, logic [19:0] adc_t, logic [15:0] adc_h);
		longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint h1, h2, h3, h4, h5, h6;
		longint v1, v2, d, t_fine, temp, p, x, a, b, c, e, f, g;
		logic [31:0] press;
		logic held;
		t1 = longint'(calib_temp[15:0]);
		t2 = longint'($signed(calib_temp[31:16]));
		t3 = longint'($signed(calib_temp[47:32]));
		p1 = longint'(calib_press_a[15:0]);
		p2 = longint'($signed(calib_press_a[31:16]));
		p3 = longint'($signed(calib_press_a[47:32]));
		p4 = longint'($signed(calib_press_a[63:48]));
		p5 = longint'($signed(calib_press_b[15:0]));
		p6 = longint'($signed(calib_press_b[31:16]));
		p7 = longint'($signed(calib_press_b[47:32]));
		p8 = longint'($signed(calib_press_b[63:48]));
		p9 = longint'($signed(calib_press_nine));
		h1 = longint'(calib_humid[7:0]);
		h2 = longint'($signed(calib_humid[23:8]));
		h3 = longint'(calib_humid[31:24]);
		h4 = longint'($signed({calib_humid[39:32], calib_humid[43:40]}));
		h5 = longint'($signed({calib_humid[55:48], calib_humid[47:44]}));
		h6 = longint'($signed(calib_humid[63:56]));

		// temperature
		v1 = s32(((longint'(adc_t) >>> 3) - (t1 <<< 1)) * t2) >>> 11;
		d = (longint'(adc_t) >>> 4) - t1;
		v2 = s32((s32(d * d) >>> 12) * t3) >>> 14;
		t_fine = s32(v1 + v2);
		temp = s32(t_fine * 5 + 128) >>> 8;

		// pressure, 64-bit wrapping
		v1 = t_fine - 128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) <<< 17);
		v2 = v2 + (p4 <<< 35);
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
		v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
		if (v1 == 0) begin
			held = 1'b1;
			press = last_pressure;
		end else begin
			held = 1'b0;
			p = 1048576 - longint'(adc_p);
			p = ((p <<< 31) - v2) * 3125;
			if (p == 64'sh8000_0000_0000_0000 && v1 == -1) p = p;
			else p = p / v1;
			a = p >>> 13;
			v1 = (p9 * a * a) >>> 25;
			v2 = (p8 * p) >>> 19;
			p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
			press = p[31:0];
			last_pressure = press;
		end

		// humidity
		x = s32(t_fine - 76800);
		a = s32((longint'(adc_h) <<< 14) - (h4 <<< 20) - h5 * x + 16384) >>> 15;
		b = s32(x * h6) >>> 10;
		c = (s32(x * h3) >>> 11) + 32768;
		e = (s32(b * c) >>> 10) + 2097152;
		e = s32(e * h2 + 8192) >>> 14;
		x = s32(a * e);
		f = x >>> 15;
		g = s32((s32(f * f) >>> 7) * h1) >>> 4;
		x = s32(x - g);
		if (x < 0) x = 0;
		if (x > 419430400) x = 419430400;

		exp_temp.push_back(temp[31:0]);
		exp_press.push_back(press);
		exp_humid.push_back(x[28:12]);
		exp_held.push_back(held);
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
	endtask

	// Compare one result with the oldest expectation
	task check_result(logic [31:0] t, logic [31:0] p, logic [16:0] h, logic hd);
		if (exp_temp.size() == 0) begin
			report("unexpected result", t, '0);
			return;
		end
		checked++;
		if (hd) held_seen++;
		if (h == 17'd0 || h == 17'd102400) clamp_seen++;
		if (t !== exp_temp[0]) report("temp_centideg", t, exp_temp[0]);
		if (p !== exp_press[0]) report("pressure_q24_8", p, exp_press[0]);
		if (h !== exp_humid[0]) report("humidity_q22_10", {15'd0, h}, {15'd0, exp_humid[0]});
		if (hd !== exp_held[0]) report("pressure_held", {31'd0, hd}, {31'd0, exp_held[0]});
		void'(exp_temp.pop_front());
		void'(exp_press.pop_front());
		void'(exp_humid.pop_front());
		void'(exp_held.pop_front());
	endtask
endclass

module env_sensor_compensation_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import esc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [19:0] raw_pressure = '0;
	logic [19:0] raw_temperature = '0;
	logic [15:0] raw_humidity = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic signed [31:0] temp_centideg;
	logic signed [31:0] pressure_q24_8;
	logic [16:0] humidity_q22_10;
	logic pressure_held;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	word_t cfg_data = '0;

	compensation_scoreboard sb = new();
	int idle_cycles = 0;
	int sent = 0;
	bit long_hold = 1'b0;
	bit drain_pause = 1'b0;

	env_sensor_compensation uut (.*);

	always #4 clk = ~clk;

	// Count cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d results pending", sb.pending());
			$display("Verification failed");
			$finish;
		end
	end

	// Check each accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(temp_centideg, pressure_q24_8, humidity_q22_10, pressure_held);
	end

	// Receiver: random stalls, one long hold-off when requested
	initial begin
		int n;
		int k;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				for (k = 0; k < 1000; k++) @(posedge clk);
				long_hold = 1'b0;
			end
			n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic write_cfg(logic [2:0] idx, word_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send(logic [19:0] p, logic [19:0] t, logic [15:0] h, bit gaps);
		int n;
		n = gaps ? $urandom_range(0, 5) : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_pressure <= p;
		raw_temperature <= t;
		raw_humidity <= h;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(p, t, h);
		sent++;
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending() != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	function automatic word_t rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Typical factory calibration with a little random spread
	task automatic load_typical();
		write_cfg(REG_CALIB_TEMP, 64'({16'd50, 16'd26000 + 16'($urandom_range(0, 1000)),
			16'd27500 + 16'($urandom_range(0, 1000))}));
		write_cfg(REG_CALIB_PA, {16'd7000, -16'sd8, 16'd36000 - 16'($urandom_range(0, 1000)),
			16'd36000 + 16'($urandom_range(0, 2000))});
		write_cfg(REG_CALIB_PB, {-16'sd12000 + 16'sd0, 16'd15500, -16'sd7, 16'd140});
		write_cfg(REG_CALIB_P9, 64'(16'sd5000 - 16'($urandom_range(0, 200))));
		write_cfg(REG_CALIB_HUMID, {8'h1E, 8'h41, 8'h03, 8'h14, 8'hE4, 8'h00, 8'h01, 8'h4B});
	endtask

	task automatic load_random();
		write_cfg(REG_CALIB_TEMP, rand64());
		write_cfg(REG_CALIB_PA, rand64());
		write_cfg(REG_CALIB_PB, rand64());
		write_cfg(REG_CALIB_P9, rand64());
		write_cfg(REG_CALIB_HUMID, rand64());
	endtask

	task automatic random_items(int count);
		int i;
		for (i = 0; i < count; i++) begin
			case ($urandom_range(0, 3))
				0: send(20'($urandom()), 20'($urandom()), 16'($urandom()), 1'b1);
				default: send(20'd300000 + 20'($urandom_range(0, 400000)),
					20'd480000 + 20'($urandom_range(0, 120000)),
					16'd20000 + 16'($urandom_range(0, 30000)), 1'b1);
			endcase
		end
	endtask

	initial begin
		int i;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset calibration: divisor zero, pressure held at zero
		send(20'd0, 20'd0, 16'd0, 1'b0);
		send(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0);
		drain();

		// Directed: field extremes under typical calibration
		load_typical();
		send(20'd0, 20'd0, 16'd0, 1'b0);
		send(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0);
		send(20'd415148, 20'd519888, 16'd30000, 1'b0);
		send(20'h80000, 20'h80000, 16'h8000, 1'b0);
		send(20'd350000, 20'd500000, 16'd0, 1'b0);
		send(20'd350000, 20'd500000, 16'hFFFF, 1'b0);
		drain();

		// Directed: P1 zero holds the last pressure
		write_cfg(REG_CALIB_PA, 64'h0000_0000_0000_0000);
		send(20'd415148, 20'd519888, 16'd30000, 1'b0);
		send(20'd1, 20'd2, 16'd3, 1'b0);
		drain();

		// Directed: all-ones and extreme calibration
		write_cfg(REG_CALIB_TEMP, 64'hFFFF_FFFF_FFFF);
		write_cfg(REG_CALIB_PA, 64'hFFFF_FFFF_FFFF_FFFF);
		write_cfg(REG_CALIB_PB, 64'hFFFF_FFFF_FFFF_FFFF);
		write_cfg(REG_CALIB_P9, 64'hFFFF);
		write_cfg(REG_CALIB_HUMID, 64'hFFFF_FFFF_FFFF_FFFF);
		send(20'd0, 20'hFFFFF, 16'hFFFF, 1'b0);
		send(20'hFFFFF, 20'd0, 16'd0, 1'b0);
		drain();
		write_cfg(REG_CALIB_TEMP, 64'h8000_8000_FFFF);
		write_cfg(REG_CALIB_PA, 64'h8000_7FFF_8000_FFFF);
		write_cfg(REG_CALIB_PB, 64'h7FFF_8000_7FFF_8000);
		write_cfg(REG_CALIB_P9, 64'h8000);
		write_cfg(REG_CALIB_HUMID, 64'h7F80_0F7F_FF7F_FF00);
		send(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0);
		send(20'd0, 20'd123456, 16'd1, 1'b0);
		drain();

		// Random phases, mixing realistic and random calibration (random every third phase)
		for (i = 0; i < 10; i++) begin
			if (i % 3 == 2) load_random();
			else load_typical();
			if (i == 4) begin
				long_hold = 1'b1;
			end
			random_items(95);
			drain();
		end

		$display("Checked %0d results over %0d transactions (%0d held, %0d clamped humidity)",
			sb.checked, sent, sb.held_seen, sb.clamp_seen);
		$display("Calibration swept between zero, typical, random and extreme settings");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

/* files.f */
src/esc_pkg.sv
src/env_sensor_compensation.sv
tb/env_sensor_compensation_tb.sv
